FILE: src/chtk_pkg.sv
// Package for the chained hash table unit: command and status codes,
// controller states. No dependencies.
package chtk_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_UPDATE = 2'd2,
        CMD_DELETE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_WALK,
        S_FREE,
        S_INIT,
        S_OUT
    } state_t;

endpackage

FILE: src/chtk_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module chtk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: src/chained_hash_table_by_key_unit.sv
// Chained hash table unit: controller plus bucket, node, link and free-list RAMs.
// Depends on chtk_pkg and chtk_ram.
//
// One command at a time. After reset a clearing pass nulls the bucket heads
// and fills the free stack; no word is taken meanwhile. Insert reads the
// bucket head and free-stack top, then links a new node at the chain head;
// lookup, update and delete walk the chain one node RAM read per step, and
// delete also pushes the node back; the result then waits in an output register.
module chained_hash_table_by_key_unit #(
    parameter int BUCKETS = 128,
    parameter int NODES   = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [30:0] s_key_id,
    input  logic [63:0] s_name_word,
    input  logic [7:0]  s_age_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [63:0] m_found_name,
    output logic [7:0]  m_found_age
);
    import chtk_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NW = $clog2(NODES);
    localparam int LW = NW + 1;
    localparam int IW = $clog2(((BUCKETS > NODES) ? BUCKETS : NODES) + 1);
    localparam int ILAST = ((BUCKETS > NODES) ? BUCKETS : NODES) - 1;
    localparam logic [LW-1:0] NIL = LW'(NODES);
    localparam int NDW = 31 + 64 + 8;

    state_t state_reg, state_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [30:0] key_reg, key_next;
    logic [63:0] name_reg, name_next;
    logic [7:0]  age_reg, age_next;
    logic [BW-1:0] bkt_reg, bkt_next;
    logic [LW-1:0] cur_reg, cur_next, prev_reg, prev_next;
    logic [LW-1:0] top_reg, top_next;
    logic [LW-1:0] steps_reg, steps_next;
    logic [IW-1:0] init_reg, init_next;
    logic        phase_reg, phase_next;
    logic [1:0]  st_reg, st_next;
    logic [63:0] oname_reg, oname_next;
    logic [7:0]  oage_reg, oage_next;

    logic          bh_we;
    logic [BW-1:0] bh_wa, bh_ra;
    logic [LW-1:0] bh_wd, bh_rd;
    logic          nd_we;
    logic [NW-1:0] nd_wa, nd_ra;
    logic [NDW-1:0] nd_wd, nd_rd;
    logic          lk_we;
    logic [NW-1:0] lk_wa, lk_ra;
    logic [LW-1:0] lk_wd, lk_rd;
    logic          fs_we;
    logic [NW-1:0] fs_wa, fs_ra;
    logic [NW-1:0] fs_wd, fs_rd;

    logic [30:0] rd_key;
    logic [63:0] rd_name;
    logic [7:0]  rd_age;
    assign {rd_key, rd_name, rd_age} = nd_rd;

    chtk_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head (
        .aclk(aclk), .we(bh_we), .waddr(bh_wa), .wdata(bh_wd),
        .raddr(bh_ra), .rdata(bh_rd));
    chtk_ram #(.WIDTH(NDW), .DEPTH(NODES)) u_node (
        .aclk(aclk), .we(nd_we), .waddr(nd_wa), .wdata(nd_wd),
        .raddr(nd_ra), .rdata(nd_rd));
    chtk_ram #(.WIDTH(LW), .DEPTH(NODES)) u_link (
        .aclk(aclk), .we(lk_we), .waddr(lk_wa), .wdata(lk_wd),
        .raddr(lk_ra), .rdata(lk_rd));
    chtk_ram #(.WIDTH(NW), .DEPTH(NODES)) u_free (
        .aclk(aclk), .we(fs_we), .waddr(fs_wa), .wdata(fs_wd),
        .raddr(fs_ra), .rdata(fs_rd));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            init_reg  <= '0;
            top_reg   <= LW'(NODES);
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            init_reg  <= init_next;
            top_reg   <= top_next;
            phase_reg <= phase_next;
        end
        cmd_reg   <= cmd_next;
        key_reg   <= key_next;
        name_reg  <= name_next;
        age_reg   <= age_next;
        bkt_reg   <= bkt_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        steps_reg <= steps_next;
        st_reg    <= st_next;
        oname_reg <= oname_next;
        oage_reg  <= oage_next;
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = (state_reg == S_OUT);
    assign m_status     = st_reg;
    assign m_found_name = oname_reg;
    assign m_found_age  = oage_reg;

    always_comb begin
        state_next = state_reg;
        init_next  = init_reg;
        top_next   = top_reg;
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        name_next  = name_reg;
        age_next   = age_reg;
        bkt_next   = bkt_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        steps_next = steps_reg;
        st_next    = st_reg;
        oname_next = oname_reg;
        oage_next  = oage_reg;
        bh_we = 1'b0; bh_wa = bkt_reg; bh_wd = NIL; bh_ra = bkt_reg;
        nd_we = 1'b0; nd_wa = cur_reg[NW-1:0];
        nd_wd = {key_reg, name_reg, age_reg};
        nd_ra = cur_reg[NW-1:0];
        lk_we = 1'b0; lk_wa = cur_reg[NW-1:0]; lk_wd = bh_rd;
        lk_ra = cur_reg[NW-1:0];
        fs_we = 1'b0; fs_wa = top_reg[NW-1:0]; fs_wd = cur_reg[NW-1:0];
        fs_ra = NW'(top_reg - LW'(1));
        case (state_reg)
            S_INIT: begin
                bh_we = (init_reg < IW'(BUCKETS));
                bh_wa = BW'(init_reg);
                fs_we = (init_reg < IW'(NODES));
                fs_wa = NW'(init_reg);
                fs_wd = NW'(init_reg);
                init_next = init_reg + IW'(1);
                if (init_reg == IW'(ILAST)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd_next  = s_cmd;
                key_next  = s_key_id;
                name_next = s_name_word;
                age_next  = s_age_value;
                bkt_next  = BW'(s_key_id % BUCKETS);
                bh_ra     = BW'(s_key_id % BUCKETS);
                oname_next = '0;
                oage_next  = '0;
                st_next    = ST_OK;
                prev_next  = NIL;
                steps_next = '0;
                phase_next = 1'b0;
                if (s_valid) begin
                    if (s_cmd == CMD_INSERT && top_reg == '0) begin
                        st_next    = ST_FULL;
                        state_next = S_OUT;
                    end else begin
                        state_next = S_HEAD;
                    end
                end
            end
            S_HEAD: begin
                // bucket head and free-stack top are now on rdata
                if (cmd_reg == CMD_INSERT) begin
                    if (!phase_reg) begin
                        phase_next = 1'b1;
                    end else begin
                        nd_we = 1'b1; nd_wa = fs_rd;
                        lk_we = 1'b1; lk_wa = fs_rd; lk_wd = bh_rd;
                        bh_we = 1'b1; bh_wd = {1'b0, fs_rd};
                        top_next = top_reg - LW'(1);
                        state_next = S_OUT;
                    end
                end else begin
                    cur_next   = bh_rd;
                    nd_ra      = bh_rd[NW-1:0];
                    lk_ra      = bh_rd[NW-1:0];
                    phase_next = 1'b0;
                    if (bh_rd >= NIL) begin
                        st_next    = ST_NOTFOUND;
                        state_next = S_OUT;
                    end else begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (rd_key == key_reg) begin
                    case (cmd_reg)
                        CMD_LOOKUP: begin
                            oname_next = rd_name;
                            oage_next  = rd_age;
                            state_next = S_OUT;
                        end
                        CMD_UPDATE: begin
                            nd_we = 1'b1;
                            nd_wd = {rd_key, name_reg, age_reg};
                            state_next = S_OUT;
                        end
                        default: begin
                            if (prev_reg >= NIL) begin
                                bh_we = 1'b1; bh_wd = lk_rd;
                            end else begin
                                lk_we = 1'b1; lk_wa = prev_reg[NW-1:0];
                                lk_wd = lk_rd;
                            end
                            state_next = S_FREE;
                        end
                    endcase
                end else begin
                    steps_next = steps_reg + LW'(1);
                    if (lk_rd >= NIL || steps_reg == LW'(NODES - 1)) begin
                        st_next    = ST_NOTFOUND;
                        state_next = S_OUT;
                    end else begin
                        prev_next = cur_reg;
                        cur_next  = lk_rd;
                        nd_ra     = lk_rd[NW-1:0];
                        lk_ra     = lk_rd[NW-1:0];
                    end
                end
            end
            S_FREE: begin
                if (top_reg < NIL) begin
                    fs_we = 1'b1;
                    top_next = top_reg + LW'(1);
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
